>>> design/tcc_pkg.sv
// ============================================================================
// tcc_pkg
// Shared types and constants for the text console cursor controller.
// ============================================================================
package tcc_pkg;

   localparam int COORD_W   = 8;
   localparam int CODE_W    = 8;
   localparam int COLOR_W   = 32;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 2;

   localparam int TAB_WIDTH_DEFAULT = 4;
   localparam int MAX_RESULTS       = 8;
   localparam int QUEUE_DEPTH       = 4;

   localparam int REQ_DATA_W   = 8;
   localparam int RSP_FIELDS_W = CODE_W + 2 * COORD_W + 2 * COLOR_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [COORD_W-1:0] COLUMNS_RESET = 8'd80;
   localparam logic [COORD_W-1:0] ROWS_RESET    = 8'd25;
   localparam logic [COLOR_W-1:0] FG_RESET      = 32'h00D0_D0D0;
   localparam logic [COLOR_W-1:0] BG_RESET      = 32'h0000_0000;

   localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CODE_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CODE_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CODE_W-1:0] CHAR_SPACE     = 8'h20;

   typedef enum logic [CMD_W-1:0] {
      CMD_DRAW   = 2'd0,
      CMD_SCROLL = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEXT_COLUMNS = 2'd0,
      CSR_TEXT_ROWS    = 2'd1,
      CSR_FG_COLOR     = 2'd2,
      CSR_BG_COLOR     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_CLEAR,
      KIND_NEWLINE,
      KIND_RETURN,
      KIND_BACKSPACE,
      KIND_TAB,
      KIND_PRINT
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CODE_W-1:0]   code;
   } queue_entry_type;

   // effective geometry: zero already mapped to one
   typedef struct packed {
      logic [COORD_W-1:0] cols;
      logic [COORD_W-1:0] rows;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
   } cfg_type;

endpackage

>>> design/tcc_front.sv
// ============================================================================
// tcc_front
// Accepts request transactions, decodes them into a command kind and holds
// them in a short queue for the back end.
// ============================================================================
module tcc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tuser,   // [0] req_type
   input  logic [7:0]              req_tdata,   // [7:0] char_code
   output logic                    q_valid,
   input  logic                    q_ready,
   output tcc_pkg::queue_entry_type q_entry
);
   import tcc_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   queue_entry_type       entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]         count_ff, count_in;
   queue_entry_type       decoded;
   logic                  push, pop;

   always_comb begin
      decoded.code = req_tdata[CODE_W-1:0];
      priority if (req_tuser) begin
         decoded.kind = KIND_CLEAR;
      end else if (req_tdata == CHAR_NEWLINE) begin
         decoded.kind = KIND_NEWLINE;
      end else if (req_tdata == CHAR_RETURN) begin
         decoded.kind = KIND_RETURN;
      end else if (req_tdata == CHAR_BACKSPACE) begin
         decoded.kind = KIND_BACKSPACE;
      end else if (req_tdata == CHAR_TAB) begin
         decoded.kind = KIND_TAB;
      end else begin
         decoded.kind = KIND_PRINT;
      end
   end

   assign req_tready = (count_ff != (PtrW+1)'(QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_entry    = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> design/tcc_back.sv
// ============================================================================
// tcc_back
// Executes queued requests against the cursor, one command per cycle while
// the response output is not stalled, into the response output register.
// ============================================================================
module tcc_back #(
   parameter int TAB_WIDTH = tcc_pkg::TAB_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tcc_pkg::cfg_type              cfg,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  tcc_pkg::queue_entry_type      q_entry,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tcc_pkg::CMD_W-1:0]     rsp_tuser,
   output logic [tcc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import tcc_pkg::*;

   localparam int RemW = $clog2(TAB_WIDTH + 1);
   localparam int CntW = $clog2(MAX_RESULTS + 1);
   localparam int TabEntries = 2 ** COORD_W;

   typedef logic [RemW-1:0] tab_table_type [TabEntries];

   // spaces needed to reach the next tab stop, per column
   function automatic tab_table_type build_tab_table();
      tab_table_type t;
      for (int i = 0; i < TabEntries; i++) begin
         t[i] = RemW'(TAB_WIDTH - (i % TAB_WIDTH));
      end
      return t;
   endfunction

   localparam tab_table_type TabTable = build_tab_table();

   logic [COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic               active_ff, active_in;
   logic [RemW-1:0]    remain_ff, remain_in;
   logic [CODE_W-1:0]  glyph_ff, glyph_in;
   logic [CntW-1:0]    cnt_ff, cnt_in, cnt_base;

   logic               rsp_valid_ff, rsp_valid_in;
   cmd_type            cmd_ff, cmd;
   logic [CODE_W-1:0]  out_glyph_ff, out_glyph;
   logic [COORD_W-1:0] out_col_ff, out_col, out_row_ff, out_row;
   logic [COLOR_W-1:0] ink_ff, ink, paper_ff;
   logic               last_ff, last_out;

   logic               adv, step_en, emit, fire, last_step;
   logic [COORD_W-1:0] rows_m1, cols_m1, col_s, row_s;
   logic               is_print;
   logic [CODE_W-1:0]  p_glyph;
   logic [RemW-1:0]    p_remain;
   logic [COORD_W-1:0] p_col, p_row;

   assign adv     = !rsp_valid_ff || rsp_tready;
   assign step_en = adv && (active_ff || q_valid);
   assign q_ready = adv && !active_ff;

   assign rows_m1 = cfg.rows - 1'b1;
   assign cols_m1 = cfg.cols - 1'b1;
   // clamp at the start of a request, in case geometry changed
   assign col_s   = (col_ff > cfg.cols) ? cfg.cols : col_ff;
   assign row_s   = (row_ff > rows_m1) ? rows_m1 : row_ff;

   always_comb begin
      emit      = 1'b0;
      last_step = 1'b0;
      cmd       = CMD_DRAW;
      out_glyph = '0;
      out_col   = '0;
      out_row   = '0;
      ink       = '0;
      col_in    = col_ff;
      row_in    = row_ff;
      active_in = active_ff;
      remain_in = remain_ff;
      glyph_in  = glyph_ff;
      is_print  = 1'b0;
      p_glyph   = glyph_ff;
      p_remain  = remain_ff;
      p_col     = col_ff;
      p_row     = row_ff;
      if (step_en) begin
         if (active_ff) begin
            is_print = 1'b1;
         end else begin
            unique case (q_entry.kind)
               KIND_CLEAR: begin
                  emit      = 1'b1;
                  last_step = 1'b1;
                  cmd       = CMD_CLEAR;
                  col_in    = '0;
                  row_in    = '0;
               end
               KIND_NEWLINE: begin
                  col_in = '0;
                  if (row_s == rows_m1) begin
                     emit      = 1'b1;
                     last_step = 1'b1;
                     cmd       = CMD_SCROLL;
                     row_in    = rows_m1;
                  end else begin
                     row_in = row_s + 1'b1;
                  end
               end
               KIND_RETURN: begin
                  col_in = '0;
                  row_in = row_s;
               end
               KIND_BACKSPACE: begin
                  emit      = 1'b1;
                  last_step = 1'b1;
                  out_glyph = CHAR_SPACE;
                  ink       = cfg.bg;
                  priority if (col_s != '0) begin
                     out_col = col_s - 1'b1;
                     out_row = row_s;
                  end else if (row_s != '0) begin
                     out_col = cols_m1;
                     out_row = row_s - 1'b1;
                  end else begin
                     out_col = '0;
                     out_row = '0;
                  end
                  col_in = out_col;
                  row_in = out_row;
               end
               KIND_TAB: begin
                  is_print = 1'b1;
                  p_glyph  = CHAR_SPACE;
                  p_remain = TabTable[col_s];
                  p_col    = col_s;
                  p_row    = row_s;
               end
               KIND_PRINT: begin
                  is_print = 1'b1;
                  p_glyph  = q_entry.code;
                  p_remain = RemW'(1);
                  p_col    = col_s;
                  p_row    = row_s;
               end
               default: begin
                  col_in = col_ff;
               end
            endcase
         end

         if (is_print) begin
            emit     = 1'b1;
            glyph_in = p_glyph;
            if ((p_col >= cfg.cols) && (p_row == rows_m1)) begin
               // wrap off the bottom: scroll now, draw in the next step
               cmd       = CMD_SCROLL;
               col_in    = '0;
               row_in    = rows_m1;
               remain_in = p_remain;
               active_in = 1'b1;
            end else begin
               out_glyph = p_glyph;
               ink       = cfg.fg;
               if (p_col >= cfg.cols) begin
                  out_col = '0;
                  out_row = p_row + 1'b1;
               end else begin
                  out_col = p_col;
                  out_row = p_row;
               end
               col_in    = out_col + 1'b1;
               row_in    = out_row;
               remain_in = p_remain - 1'b1;
               active_in = (p_remain != RemW'(1));
               last_step = (p_remain == RemW'(1));
            end
         end
      end
   end

   // commands past the limit are dropped; the last one kept carries tlast
   assign cnt_base = active_ff ? cnt_ff : '0;
   assign fire     = emit && (cnt_base != CntW'(MAX_RESULTS));
   assign last_out = last_step || (cnt_base == CntW'(MAX_RESULTS - 1));
   assign cnt_in   = step_en ? cnt_base + CntW'(fire) : cnt_ff;
   assign rsp_valid_in = adv ? fire : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      glyph_ff  <= glyph_in;
      if (adv && fire) begin
         cmd_ff       <= cmd;
         out_glyph_ff <= out_glyph;
         out_col_ff   <= out_col;
         out_row_ff   <= out_row;
         ink_ff       <= ink;
         paper_ff     <= cfg.bg;
         last_ff      <= last_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = cmd_ff;
   assign rsp_tdata  = RSP_DATA_W'({paper_ff, ink_ff, out_row_ff, out_col_ff,
                                    out_glyph_ff});

   // cursor row never left beyond the last row by a step
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      step_en |=> (row_ff <= $past(rows_m1)))
      else $error("cursor row past last row after a step");

   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MAX_RESULTS))
      else $error("result count above limit");

   a_active_remain: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (remain_ff != '0))
      else $error("sequence active with nothing left to draw");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (step_en && emit && last_step) |=> !active_ff)
      else $error("sequence continues after its final command");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !$past(active_ff) && !$past(reset)) |-> $past(q_valid && q_ready))
      else $error("sequence started without taking a request");

endmodule

>>> design/text_console_cursor_controller.sv
// ============================================================================
// text_console_cursor_controller
// Text cursor tracking and framebuffer command generation.
// ============================================================================
// Accepts one request transaction per cycle into a four-entry queue while
// the queue has room. A newline or carriage return that draws nothing sends
// no response. A tab draws spaces up to the next tab stop (at most
// TAB_WIDTH of them), and a wrap off the bottom row adds a scroll command;
// while such a sequence runs the back end takes no new request and the
// queue backs up.
// At most eight commands are sent per request; tlast marks the final one.
// Config registers may only be written while the block is idle.
module text_console_cursor_controller #(
   parameter int TAB_WIDTH = tcc_pkg::TAB_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,  // [0] req_type
   input  logic [tcc_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] char_code
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tcc_pkg::CMD_W-1:0]        rsp_tuser,  // [1:0] command
   // [7:0] glyph_code, [15:8] cell_column, [23:16] cell_row,
   // [55:24] ink_color, [87:56] paper_color
   output logic [tcc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,  // last_result
   input  logic                             csr_wen,
   input  logic [tcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcc_pkg::COLOR_W-1:0]      csr_wdata
);
   import tcc_pkg::*;

   logic [COORD_W-1:0] cols_ff, rows_ff;
   logic [COLOR_W-1:0] fg_ff, bg_ff;
   cfg_type            cfg;
   logic               q_valid, q_ready;
   queue_entry_type    q_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLUMNS_RESET;
         rows_ff <= ROWS_RESET;
         fg_ff   <= FG_RESET;
         bg_ff   <= BG_RESET;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEXT_COLUMNS: cols_ff <= csr_wdata[COORD_W-1:0];
            CSR_TEXT_ROWS:    rows_ff <= csr_wdata[COORD_W-1:0];
            CSR_FG_COLOR:     fg_ff   <= csr_wdata;
            CSR_BG_COLOR:     bg_ff   <= csr_wdata;
            default:          cols_ff <= cols_ff;
         endcase
      end
   end

   // zero geometry behaves as one
   assign cfg.cols = (cols_ff == '0) ? COORD_W'(1) : cols_ff;
   assign cfg.rows = (rows_ff == '0) ? COORD_W'(1) : rows_ff;
   assign cfg.fg   = fg_ff;
   assign cfg.bg   = bg_ff;

   tcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry)
   );

   tcc_back #(
      .TAB_WIDTH (TAB_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> test/text_console_cursor_controller_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// text_console_cursor_controller_tb
// Drives character and clear requests into the cursor controller, mirrors the
// cursor and geometry registers in a local model, and checks every drawing
// command field by field. A short directed table runs first, then randomized
// traffic over several screen geometries, with random source and sink stalls.
// ============================================================================
module text_console_cursor_controller_tb;
   import tcc_pkg::*;

   localparam int TAB_W       = TAB_WIDTH_DEFAULT;
   localparam int SETTLE      = 24;
   localparam int DRAIN_LIMIT = 5000;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DIR_N       = 31;

   // one drawing command as the sink should see it
   typedef struct packed {
      cmd_type            cmd;
      logic [CODE_W-1:0]  glyph;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [COLOR_W-1:0] ink;
      logic [COLOR_W-1:0] paper;
      logic               last;
   } cmd_rec_type;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [COLOR_W-1:0]   paper;
      logic [COLOR_W-1:0]   ink;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
      logic [CODE_W-1:0]    glyph;
   } rsp_word_type;

   // hand-written expectation for a single-command request
   typedef struct packed {
      logic        typed;
      cmd_rec_type rec;
   } pin_type;

   typedef struct packed {
      logic               is_csr;
      csr_index_type      csr_idx;
      logic [COLOR_W-1:0] csr_val;
      logic               clr;
      logic [CODE_W-1:0]  code;
      pin_type            pin;
   } dir_row_type;

   localparam pin_type NO_PIN = '0;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic                   req_tuser;    // [0] req_type
   logic [REQ_DATA_W-1:0]  req_tdata;    // [7:0] char_code
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [CMD_W-1:0]       rsp_tuser;    // [1:0] command
   // [7:0] glyph_code, [15:8] cell_column, [23:16] cell_row,
   // [55:24] ink_color, [87:56] paper_color
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;    // last_result
   logic                   csr_wen;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [COLOR_W-1:0]     csr_wdata;

   logic                   idle_on;
   int                     mismatches;

   // register mirror and cursor
   logic [COORD_W-1:0]     cfg_cols;
   logic [COORD_W-1:0]     cfg_rows;
   logic [COLOR_W-1:0]     cfg_fg;
   logic [COLOR_W-1:0]     cfg_bg;
   logic [COORD_W-1:0]     cur_col;
   logic [COORD_W-1:0]     cur_row;
   int                     n_out;

   cmd_rec_type            pending_cmds[$];
   pin_type                typed_cmds[$];
   dir_row_type            dir_tab [DIR_N];

   text_console_cursor_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      int n;
      for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // ---------------- cursor model ----------------

   function automatic logic [COORD_W-1:0] cols_now();
      return (cfg_cols == '0) ? 8'd1 : cfg_cols;
   endfunction

   function automatic logic [COORD_W-1:0] rows_now();
      return (cfg_rows == '0) ? 8'd1 : cfg_rows;
   endfunction

   // commands past the eighth are dropped, the cursor still moves
   task automatic push_cmd(input cmd_type c, input logic [CODE_W-1:0] g,
                           input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                           input logic [COLOR_W-1:0] ink, input logic [COLOR_W-1:0] paper);
      if (n_out < MAX_RESULTS) pending_cmds.push_back('{c, g, col, row, ink, paper, 1'b0});
      n_out++;
   endtask

   task automatic scroll_if_below();
      if (cur_row >= rows_now()) begin
         push_cmd(CMD_SCROLL, '0, '0, '0, '0, cfg_bg);
         cur_row = rows_now() - 8'd1;
      end
   endtask

   task automatic put_glyph(input logic [CODE_W-1:0] g);
      if (cur_col >= cols_now()) begin
         cur_col = '0;
         cur_row = cur_row + 8'd1;
         scroll_if_below();
      end
      push_cmd(CMD_DRAW, g, cur_col, cur_row, cfg_fg, cfg_bg);
      cur_col = cur_col + 8'd1;
   endtask

   task automatic track_cursor(input logic clr, input logic [CODE_W-1:0] code,
                               input pin_type pin);
      int base;
      int n;
      int i;
      base = pending_cmds.size();
      n_out = 0;
      // geometry may have shrunk under the cursor
      if (cur_col > cols_now()) cur_col = cols_now();
      if (cur_row >= rows_now()) cur_row = rows_now() - 8'd1;
      if (clr) begin
         push_cmd(CMD_CLEAR, '0, '0, '0, '0, cfg_bg);
         cur_col = '0;
         cur_row = '0;
      end else begin
         case (code)
            CHAR_NEWLINE: begin
               cur_col = '0;
               cur_row = cur_row + 8'd1;
               scroll_if_below();
            end
            CHAR_RETURN: begin
               cur_col = '0;
            end
            CHAR_BACKSPACE: begin
               if (cur_col > 0) begin
                  cur_col = cur_col - 8'd1;
               end else if (cur_row > 0) begin
                  cur_row = cur_row - 8'd1;
                  cur_col = cols_now() - 8'd1;
               end
               push_cmd(CMD_DRAW, CHAR_SPACE, cur_col, cur_row, cfg_bg, cfg_bg);
            end
            CHAR_TAB: begin
               n = TAB_W - (int'(cur_col) % TAB_W);
               for (i = 0; i < n; i++) put_glyph(CHAR_SPACE);
            end
            default: begin
               put_glyph(code);
            end
         endcase
      end
      if (pending_cmds.size() > base) pending_cmds[pending_cmds.size()-1].last = 1'b1;
      if (pin.typed) begin
         while (pending_cmds.size() > base) void'(pending_cmds.pop_back());
         pending_cmds.push_back(pin.rec);
      end
   endtask

   // ---------------- checking ----------------

   function automatic void cmp(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_cmd();
      rsp_word_type w;
      cmd_rec_type  e;
      w = rsp_tdata;
      if (pending_cmds.size() == 0) begin
         $error("command transaction with nothing expected: 0x%0h", rsp_tdata);
         mismatches++;
      end else begin
         e = pending_cmds.pop_front();
         cmp("command", e.cmd, rsp_tuser);
         cmp("glyph_code", e.glyph, w.glyph);
         cmp("cell_column", e.col, w.col);
         cmp("cell_row", e.row, w.row);
         cmp("ink_color", e.ink, w.ink);
         cmp("paper_color", e.paper, w.paper);
         cmp("last_result", e.last, rsp_tlast);
      end
   endtask

   // both handshakes and register writes are observed at the same edge
   always @(posedge clock) begin
      if (reset) begin
         cfg_cols = COLUMNS_RESET;
         cfg_rows = ROWS_RESET;
         cfg_fg   = FG_RESET;
         cfg_bg   = BG_RESET;
         cur_col  = '0;
         cur_row  = '0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_TEXT_COLUMNS: cfg_cols = csr_wdata[COORD_W-1:0];
               CSR_TEXT_ROWS:    cfg_rows = csr_wdata[COORD_W-1:0];
               CSR_FG_COLOR:     cfg_fg   = csr_wdata;
               CSR_BG_COLOR:     cfg_bg   = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) track_cursor(req_tuser, req_tdata, typed_cmds.pop_front());
         if (rsp_tvalid && rsp_tready) check_cmd();
      end
   end

   // ---------------- sink ----------------

   initial begin : rsp_sink
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            hold = $urandom_range(0, 5);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------- source ----------------

   task automatic send_req(input logic clr, input logic [CODE_W-1:0] code, input pin_type pin);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      typed_cmds.push_back(pin);
      req_tvalid <= 1'b1;
      req_tuser  <= clr;
      req_tdata  <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // wait for all commands, then for queued no-output requests to retire
   task automatic settle_idle();
      int n;
      req_tvalid <= 1'b0;
      n = 0;
      while (pending_cmds.size() != 0 && n < DRAIN_LIMIT) begin
         @(negedge clock);
         n++;
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [COLOR_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen   <= 1'b0;
      @(negedge clock);
   endtask

   function automatic pin_type pin_of(input cmd_type c, input logic [CODE_W-1:0] g,
                                      input logic [COORD_W-1:0] col,
                                      input logic [COORD_W-1:0] row,
                                      input logic [COLOR_W-1:0] ink,
                                      input logic [COLOR_W-1:0] paper);
      return '{1'b1, '{c, g, col, row, ink, paper, 1'b1}};
   endfunction

   function automatic dir_row_type req_row(input logic clr, input logic [CODE_W-1:0] code,
                                           input pin_type pin);
      return '{1'b0, CSR_TEXT_COLUMNS, '0, clr, code, pin};
   endfunction

   function automatic dir_row_type csr_row(input csr_index_type idx,
                                           input logic [COLOR_W-1:0] val);
      return '{1'b1, idx, val, 1'b0, '0, NO_PIN};
   endfunction

   initial begin
      int i;
      int ph;
      int k;
      int r;
      int count [5];
      logic clr;
      logic [CODE_W-1:0] code;
      logic [COLOR_W-1:0] cols_v, rows_v, fg_v, bg_v;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_index  = CSR_TEXT_COLUMNS;
      csr_wdata  = '0;
      idle_on    = 1'b1;
      mismatches = 0;
      count      = '{60, 30, 220, 50, 60};

      dir_tab = '{
         // reset geometry 80 x 25
         req_row(1'b1, 8'h00, pin_of(CMD_CLEAR, 8'h00, 8'd0, 8'd0, 32'd0, BG_RESET)),
         req_row(1'b0, 8'h41, pin_of(CMD_DRAW, 8'h41, 8'd0, 8'd0, FG_RESET, BG_RESET)),
         req_row(1'b0, CHAR_BACKSPACE,
                 pin_of(CMD_DRAW, CHAR_SPACE, 8'd0, 8'd0, BG_RESET, BG_RESET)),
         // backspace at home blanks the home cell
         req_row(1'b0, CHAR_BACKSPACE,
                 pin_of(CMD_DRAW, CHAR_SPACE, 8'd0, 8'd0, BG_RESET, BG_RESET)),
         req_row(1'b0, 8'hFF, pin_of(CMD_DRAW, 8'hFF, 8'd0, 8'd0, FG_RESET, BG_RESET)),
         req_row(1'b0, 8'h00, pin_of(CMD_DRAW, 8'h00, 8'd1, 8'd0, FG_RESET, BG_RESET)),
         req_row(1'b0, CHAR_TAB, NO_PIN),
         // uninterpreted control byte draws as a glyph
         req_row(1'b0, 8'h1B, pin_of(CMD_DRAW, 8'h1B, 8'd4, 8'd0, FG_RESET, BG_RESET)),
         req_row(1'b0, CHAR_RETURN, NO_PIN),
         req_row(1'b0, CHAR_NEWLINE, NO_PIN),
         req_row(1'b0, 8'h7F, pin_of(CMD_DRAW, 8'h7F, 8'd0, 8'd1, FG_RESET, BG_RESET)),
         // zero geometry acts as a single cell; cursor gets clamped
         csr_row(CSR_TEXT_COLUMNS, 32'd0),
         csr_row(CSR_TEXT_ROWS, 32'd0),
         csr_row(CSR_FG_COLOR, 32'hFFFF_FFFF),
         csr_row(CSR_BG_COLOR, 32'hFFFF_FFFF),
         req_row(1'b0, CHAR_TAB, NO_PIN),
         req_row(1'b0, CHAR_NEWLINE,
                 pin_of(CMD_SCROLL, 8'h00, 8'd0, 8'd0, 32'd0, 32'hFFFF_FFFF)),
         req_row(1'b0, 8'h78, pin_of(CMD_DRAW, 8'h78, 8'd0, 8'd0, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF)),
         req_row(1'b0, 8'h79, NO_PIN),
         req_row(1'b0, CHAR_BACKSPACE, pin_of(CMD_DRAW, CHAR_SPACE, 8'd0, 8'd0,
                                              32'hFFFF_FFFF, 32'hFFFF_FFFF)),
         req_row(1'b1, 8'h00, pin_of(CMD_CLEAR, 8'h00, 8'd0, 8'd0, 32'd0, 32'hFFFF_FFFF)),
         // widest screen: backspace wraps to the last column
         csr_row(CSR_TEXT_COLUMNS, 32'd255),
         csr_row(CSR_TEXT_ROWS, 32'd255),
         csr_row(CSR_FG_COLOR, 32'd0),
         csr_row(CSR_BG_COLOR, 32'hA5A5_5A5A),
         req_row(1'b0, CHAR_NEWLINE, NO_PIN),
         req_row(1'b0, CHAR_BACKSPACE, pin_of(CMD_DRAW, CHAR_SPACE, 8'd254, 8'd0,
                                              32'hA5A5_5A5A, 32'hA5A5_5A5A)),
         req_row(1'b0, 8'h5A, pin_of(CMD_DRAW, 8'h5A, 8'd254, 8'd0, 32'd0, 32'hA5A5_5A5A)),
         // pending wrap resolves on the next printable byte
         req_row(1'b0, 8'h71, pin_of(CMD_DRAW, 8'h71, 8'd0, 8'd1, 32'd0, 32'hA5A5_5A5A)),
         req_row(1'b0, CHAR_TAB, NO_PIN),
         req_row(1'b1, 8'hFF, pin_of(CMD_CLEAR, 8'h00, 8'd0, 8'd0, 32'd0, 32'hA5A5_5A5A))
      };

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < DIR_N; i++) begin
         if (dir_tab[i].is_csr) begin
            settle_idle();
            write_reg(dir_tab[i].csr_idx, dir_tab[i].csr_val);
         end else begin
            send_req(dir_tab[i].clr, dir_tab[i].code, dir_tab[i].pin);
         end
      end

      for (ph = 0; ph < 5; ph++) begin
         settle_idle();
         case (ph)
            0: begin
               cols_v = $urandom_range(1, 12);
               rows_v = $urandom_range(1, 4);
               fg_v   = $urandom;
               bg_v   = $urandom;
            end
            1: begin
               cols_v = 0;
               rows_v = 0;
               fg_v   = 32'hFFFF_FFFF;
               bg_v   = 32'h0;
            end
            2: begin
               // one column, tallest screen: rows advance on nearly every request
               cols_v = 1;
               rows_v = 255;
               fg_v   = $urandom;
               bg_v   = $urandom;
            end
            3: begin
               cols_v = 255;
               rows_v = $urandom_range(1, 3);
               fg_v   = 32'h0;
               bg_v   = 32'hFFFF_FFFF;
            end
            default: begin
               cols_v = $urandom_range(1, 40);
               rows_v = $urandom_range(1, 10);
               fg_v   = $urandom;
               bg_v   = $urandom;
            end
         endcase
         write_reg(CSR_TEXT_COLUMNS, cols_v);
         write_reg(CSR_TEXT_ROWS, rows_v);
         write_reg(CSR_FG_COLOR, fg_v);
         write_reg(CSR_BG_COLOR, bg_v);
         idle_on <= (ph != 4);

         for (k = 0; k < count[ph]; k++) begin
            r    = $urandom_range(0, 99);
            clr  = 1'b0;
            code = $urandom_range(0, 255);
            if (ph == 2) begin
               if (r < 20)      code = CHAR_TAB;
               else if (r < 40) code = CHAR_NEWLINE;
               else if (r < 45) code = CHAR_BACKSPACE;
               else if (r < 48) code = CHAR_RETURN;
            end else begin
               if (r < 4)       clr  = 1'b1;
               else if (r < 14) code = CHAR_NEWLINE;
               else if (r < 20) code = CHAR_RETURN;
               else if (r < 30) code = CHAR_BACKSPACE;
               else if (r < 42) code = CHAR_TAB;
            end
            send_req(clr, code, NO_PIN);
         end
      end

      settle_idle();
      if (pending_cmds.size() != 0) begin
         $error("%0d expected commands never arrived", pending_cmds.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
